// ===== sv/mwalu_pkg.sv =====
// Shared types and constants for the masked width integer ALU.
package mwalu_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned WIDTH_W     = 6;
	localparam int unsigned RESET_WIDTH = 16;
	localparam int unsigned DIV_STAGES  = DATA_W;

	typedef enum logic [3:0] {
		ACT_ADD = 4'd0,
		ACT_SUB = 4'd1,
		ACT_MUL = 4'd2,
		ACT_DIV = 4'd3,
		ACT_AND = 4'd4,
		ACT_OR  = 4'd5,
		ACT_XOR = 4'd6,
		ACT_NOT = 4'd7,
		ACT_NEG = 4'd8
	} action_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              dz;
		logic              is_div;
	} side_t;

	function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] ww);
		logic [WIDTH_W-1:0] w;
		logic [DATA_W:0]    t;
		w = (ww > WIDTH_W'(DATA_W)) ? WIDTH_W'(DATA_W) : ww;
		t = ((DATA_W+1)'(1) << w) - (DATA_W+1)'(1);
		return t[DATA_W-1:0];
	endfunction

endpackage

// ===== sv/mwalu_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module mwalu_divider (
	input  logic                             clk,
	input  logic [mwalu_pkg::DATA_W-1:0]     dividend,
	input  logic [mwalu_pkg::DATA_W-1:0]     divisor,
	output logic [mwalu_pkg::DATA_W-1:0]     quotient
);

	localparam int unsigned W = mwalu_pkg::DATA_W;
	localparam int unsigned N = mwalu_pkg::DIV_STAGES;

	logic [W-1:0] num_s [N+1];
	logic [W-1:0] den_s [N+1];
	logic [W-1:0] quo_s [N+1];
	logic [W-1:0] rem_s [N+1];

	assign num_s[0] = dividend;
	assign den_s[0] = divisor;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		always_comb begin
			trial = {rem_s[k], num_s[k][W-1-k]};
			diff  = trial - {1'b0, den_s[k]};
		end
		always_ff @(posedge clk) begin
			num_s[k+1] <= num_s[k];
			den_s[k+1] <= den_s[k];
			if (!diff[W]) begin
				rem_s[k+1] <= diff[W-1:0];
				quo_s[k+1] <= {quo_s[k][W-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= trial[W-1:0];
				quo_s[k+1] <= {quo_s[k][W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_s[N];

endmodule

// ===== sv/masked_width_integer_alu.sv =====
// Top level of the masked width integer ALU.
// Usage: pulse start with action and operands; busy is always low, so a
// transaction is taken every cycle it is offered. Operands are masked to
// word_width (APB register at address 0, reset 16, saturates at 32).
// Every action follows the same path: the operand register, the divider
// stages or their matching delay line, then the output register.
// Throughput: one transaction per cycle.
// The depth is set by the divider, which resolves one quotient bit per
// stage over 32 stages; all other actions ride a matching delay line.
// The multiplier sits in one stage, its product registered.
// Divide by a zero (masked) divisor returns 0 with divide_by_zero set.
// Reset clears all valid bits and restores word_width; transactions in
// flight are dropped. The receiver cannot stall: each result is shown for
// exactly one cycle. word_width may change only while the pipe is empty.
module masked_width_integer_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [3:0]                    action,
	input  logic [31:0]                   left_operand,
	input  logic [31:0]                   right_operand,
	output logic                          result_valid,
	output logic [31:0]                   result_value,
	output logic                          divide_by_zero
);

	localparam int unsigned W = mwalu_pkg::DATA_W;
	localparam int unsigned N = mwalu_pkg::DIV_STAGES;

	logic [mwalu_pkg::WIDTH_W-1:0] width_q;
	logic [W-1:0]                  mask;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-mwalu_pkg::WIDTH_W){1'b0}}, width_q} : '0;
	assign mask   = mwalu_pkg::width_mask(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= mwalu_pkg::WIDTH_W'(mwalu_pkg::RESET_WIDTH);
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			width_q <= pwdata[mwalu_pkg::WIDTH_W-1:0];
		end
	end

	// stage 1: masked operands
	logic          valid_s1;
	logic [3:0]    action_s1;
	logic [W-1:0]  a_s1, b_s1, mask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= action;
		a_s1      <= left_operand & mask;
		b_s1      <= right_operand & mask;
		mask_s1   <= mask;
	end

	// stage 2: everything but divide
	mwalu_pkg::side_t side_c;
	logic [W-1:0]     raw;

	always_comb begin
		raw           = '0;
		side_c.dz     = 1'b0;
		side_c.is_div = 1'b0;
		case (action_s1)
			mwalu_pkg::ACT_ADD: raw = a_s1 + b_s1;
			mwalu_pkg::ACT_SUB: raw = a_s1 - b_s1;
			mwalu_pkg::ACT_MUL: raw = a_s1 * b_s1;
			mwalu_pkg::ACT_DIV: begin
				side_c.is_div = 1'b1;
				side_c.dz     = (b_s1 == '0);
			end
			mwalu_pkg::ACT_AND: raw = a_s1 & b_s1;
			mwalu_pkg::ACT_OR:  raw = a_s1 | b_s1;
			mwalu_pkg::ACT_XOR: raw = a_s1 ^ b_s1;
			mwalu_pkg::ACT_NOT: raw = ~a_s1;
			mwalu_pkg::ACT_NEG: raw = '0 - a_s1;
			default:            raw = '0;
		endcase
		side_c.value = raw & mask_s1;
	end

	logic [W-1:0] quotient;

	mwalu_divider u_div (
		.clk      (clk),
		.dividend (a_s1),
		.divisor  (b_s1),
		.quotient (quotient)
	);

	// delay line aligned with divider output
	mwalu_pkg::side_t side_s [N];
	logic             vld_s  [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= valid_s1;
			for (int i = 1; i < N; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_c;
		for (int i = 1; i < N; i++) side_s[i] <= side_s[i-1];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		divide_by_zero <= side_s[N-1].dz;
		if (side_s[N-1].dz) begin
			result_value <= '0;
		end else if (side_s[N-1].is_div) begin
			result_value <= quotient;
		end else begin
			result_value <= side_s[N-1].value;
		end
	end

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && divide_by_zero |-> result_value == '0)
		else $error("divide by zero result not cleared");

	a_masked: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_value & ~mask) == '0)
		else $error("result exceeds word width");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> valid_s1)
		else $error("transaction lost at entry");

endmodule

// ===== tb/sv/masked_width_integer_alu_test.sv =====
// Self-checking testbench for the masked width integer ALU: predicts each transaction's result.
module masked_width_integer_alu_test;

	typedef struct {
		logic [3:0]  act;
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic        is_cfg;
		logic [5:0]  cfg_width;
	} alu_op_t;

	typedef struct {
		logic [31:0] value;
		logic        dz;
	} alu_res_t;

	localparam int PIPE_DEPTH = 34;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [3:0]  action;
	logic [31:0] left_operand, right_operand;
	logic        result_valid;
	logic [31:0] result_value;
	logic        divide_by_zero;

	alu_op_t  pending_ops[$];
	alu_res_t expected_results[$];
	logic [5:0] model_width;
	int       error_count;
	int       idle_cycles;
	int       drain_cycles;
	int       cfg_phase;
	int       stall_left;
	int       quiet_cycles;
	bit       stim_done;
	bit       no_idle;

	masked_width_integer_alu u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .left_operand(left_operand),
		.right_operand(right_operand), .result_valid(result_valid),
		.result_value(result_value), .divide_by_zero(divide_by_zero)
	);

	function automatic alu_res_t predict_alu(logic [5:0] ww, logic [3:0] act,
			logic [31:0] lhs, logic [31:0] rhs);
		alu_res_t    res;
		logic [63:0] msk, a, b, r;
		int          w;
		w = (ww > 32) ? 32 : ww;
		msk = (64'd1 << w) - 64'd1;
		a = {32'd0, lhs} & msk;
		b = {32'd0, rhs} & msk;
		r = '0;
		res.dz = 1'b0;
		case (act)
			mwalu_pkg::ACT_ADD: r = a + b;
			mwalu_pkg::ACT_SUB: r = a - b;
			mwalu_pkg::ACT_MUL: r = a * b;
			mwalu_pkg::ACT_DIV: begin
				if (b == 0) res.dz = 1'b1;
				else r = a / b;
			end
			mwalu_pkg::ACT_AND: r = a & b;
			mwalu_pkg::ACT_OR:  r = a | b;
			mwalu_pkg::ACT_XOR: r = a ^ b;
			mwalu_pkg::ACT_NOT: r = ~a;
			mwalu_pkg::ACT_NEG: r = 64'd0 - a;
			default: r = '0;
		endcase
		r = r & msk;
		res.value = r[31:0];
		return res;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 3);
			3: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(logic [3:0] act, logic [31:0] lhs, logic [31:0] rhs);
		alu_op_t op;
		op.act = act;
		op.lhs = lhs;
		op.rhs = rhs;
		op.is_cfg = 1'b0;
		op.cfg_width = '0;
		pending_ops.push_back(op);
	endtask

	task automatic queue_width(logic [5:0] ww);
		alu_op_t op;
		op.act = '0;
		op.lhs = '0;
		op.rhs = '0;
		op.is_cfg = 1'b1;
		op.cfg_width = ww;
		pending_ops.push_back(op);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		logic [5:0] widths[8];
		arst_n = 1'b0;
		widths = '{6'd16, 6'd1, 6'd32, 6'd0, 6'd63, 6'd8, 6'd33, 6'd24};
		// directed: default width, then field extremes and every action
		for (int a = 0; a < 9; a++) queue_op(4'(a), 32'hFFFF_FFFF, 32'h0001_0003);
		queue_op(mwalu_pkg::ACT_DIV, 32'h1234, 32'h0001_0000);
		queue_op(mwalu_pkg::ACT_DIV, 32'hFFFF, 32'h0);
		queue_op(mwalu_pkg::ACT_MUL, 32'hFFFF, 32'hFFFF);
		queue_op(mwalu_pkg::ACT_ADD, 32'hFFFF, 32'h1);
		queue_op(mwalu_pkg::ACT_SUB, 32'h0, 32'h1);
		queue_op(4'd9, 32'h5, 32'h5);
		queue_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(mwalu_pkg::ACT_NEG, 32'h0, 32'h0);
		queue_op(mwalu_pkg::ACT_NOT, 32'h0, 32'hFFFF_FFFF);
		for (int p = 0; p < 8; p++) begin
			queue_width(widths[p]);
			for (int i = 0; i < 105; i++)
				queue_op(4'((($urandom_range(0, 15) == 0) ? $urandom_range(9, 15)
					: $urandom_range(0, 8))), rand_operand(), rand_operand());
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: issues transactions, waits for an empty pipe before width writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0; psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
			paddr <= '0; pwdata <= '0; action <= '0;
			left_operand <= '0; right_operand <= '0;
			model_width <= 6'(mwalu_pkg::RESET_WIDTH);
			stall_left <= 0; cfg_phase <= 0; stim_done <= 1'b0; drain_cycles <= 0;
			no_idle <= 1'b0;
		end else begin
			no_idle <= (pending_ops.size() < 120);
			if (cfg_phase == 1) begin
				psel <= 1'b1; penable <= 1'b1; cfg_phase <= 2;
			end else if (cfg_phase == 2) begin
				psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; cfg_phase <= 0;
			end else if (start && busy) begin
				// hold until accepted
			end else if (stall_left > 0) begin
				start <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (pending_ops.size() == 0) begin
				start <= 1'b0;
				stim_done <= 1'b1;
			end else if (pending_ops[0].is_cfg) begin
				start <= 1'b0;
				if (expected_results.size() != 0 || start) drain_cycles <= 0;
				else if (drain_cycles < 4) drain_cycles <= drain_cycles + 1;
				else begin
					psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
					paddr <= '0;
					pwdata <= {24'd0, 2'($urandom_range(0, 3)), pending_ops[0].cfg_width};
					model_width <= pending_ops[0].cfg_width;
					cfg_phase <= 1;
					drain_cycles <= 0;
					void'(pending_ops.pop_front());
				end
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				start <= 1'b0;
				stall_left <= $urandom_range(0, 13);
			end else begin
				start <= 1'b1;
				action <= pending_ops[0].act;
				left_operand <= pending_ops[0].lhs;
				right_operand <= pending_ops[0].rhs;
				void'(pending_ops.pop_front());
			end
		end
	end

	// monitor: predicts on acceptance, checks each result strobe
	always @(posedge clk) begin
		alu_res_t exp_res;
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(
					predict_alu(model_width, action, left_operand, right_operand));
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value=%h dz=%b", $time,
						result_value, divide_by_zero);
					error_count++;
				end else begin
					exp_res = expected_results.pop_front();
					if (result_value !== exp_res.value) begin
						$display("%0t: result_value expected %h actual %h", $time,
							exp_res.value, result_value);
						error_count++;
					end
					if (divide_by_zero !== exp_res.dz) begin
						$display("%0t: divide_by_zero expected %b actual %b", $time,
							exp_res.dz, divide_by_zero);
						error_count++;
					end
				end
			end
		end
	end

	// watchdog and end of run
	initial begin
		error_count = 0;
		quiet_cycles = 0;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((start && !busy) || result_valid || cfg_phase != 0) quiet_cycles = 0;
			else quiet_cycles++;
			if (stim_done && expected_results.size() == 0) idle_cycles++;
			else idle_cycles = 0;
			if (idle_cycles > PIPE_DEPTH + 10) begin
				if (error_count == 0) $display("No mismatches found");
				else $display("Mismatches found");
				$finish;
			end else if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
